// File: rtl/gdad_pkg.sv
// shared types, constants and calendar helpers for the gregorian date adder
// no dependencies; imported by the top level
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

    localparam int ADD_WIDTH_DEF = 16;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 16;
    localparam int DOY_W   = 9;
    localparam int STAT_W  = 2;
    localparam int R400_W  = 9;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    localparam logic [YEAR_W-1:0] MAX_YEAR   = 14'd9999;
    localparam logic [R400_W-1:0] CYCLE_400  = 9'd400;
    localparam logic [R400_W-1:0] CYCLE_LAST = 9'd399;
    localparam logic [DOY_W-1:0]  DAYS_LEAP  = 9'd366;
    localparam logic [DOY_W-1:0]  DAYS_NORM  = 9'd365;
    localparam logic [DAY_W-1:0]  FEB_LEAP   = 5'd29;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_INVALID  = 2'd1;
    localparam status_t STAT_OVERFLOW = 2'd2;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // leap test from the two low year bits and the year modulo 400
    function automatic logic is_leap(input logic [1:0] ylow, input logic [R400_W-1:0] r400);
        return (ylow == 2'b00) && (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
    endfunction

    // month length, zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [MONTH_W-1:0] idx;
        idx = m - MONTH_JAN;
        if (m == MONTH_FEB && leap)
            return FEB_LEAP;
        else if (m >= MONTH_JAN && m <= MONTH_DEC)
            return MONTH_LEN[idx];
        else
            return '0;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gdad_addsub.sv
// shared adder / subtractor used by the arithmetic steps of the date sequencer
// standalone, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module gdad_addsub #(
    parameter int W = 21
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic         sub,   // 1 = a - b
    output logic      [W-1:0] sum,
    output logic              carry  // on subtract: 1 means a >= b
);

    logic [W-1:0] b_op;
    logic [W:0]   full;

    assign b_op  = sub ? ~b : b;
    assign full  = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, sub};
    assign sum   = full[W-1:0];
    assign carry = full[W];

endmodule

`default_nettype wire

// File: rtl/gregorian_date_add_days_top.sv
// top level of the gregorian date adder: sequencer, working registers, output register
// depends on gdad_pkg and gdad_addsub
`timescale 1ns / 1ps
`default_nettype none

// usage
//  - input stream (s_*): one transfer carries a start date and a day count
//  - output stream (m_*): one transfer per input with the new date, the day of
//    year, days left, leap flag and status (0 ok, 1 invalid date, 2 year overflow)
//  - one item is worked at a time; s_tready is high only while the sequencer
//    is idle, so the next transfer can be taken while a result still waits
//  - an item runs through the year reduction, the range check, the day of year,
//    days left, the total, the month walk and the finish; the walk dominates: one
//    month per cycle on the shared add/subtract unit
//  - the next input transfer is taken only once the result is registered and the
//    sequencer is back in idle, so items never overlap
//  - an invalid date skips the walk and goes from the check to the finish step
//  - the year is reduced modulo 400 by repeated subtraction at the start,
//    after which leap years are tracked incrementally
//  - reset (rst_n low, asynchronous) returns the sequencer to idle and drops
//    m_tvalid; no memory needs clearing
//  - a stalled receiver holds the result in the output register; a finished
//    item then waits in its last step until the register frees up
module gregorian_date_add_days_top
    #(
    parameter int ADD_WIDTH = gdad_pkg::ADD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // start_month[3:0], start_day[8:4], start_year[22:9], add_count[38:23], zero pad
    input  wire logic [gdad_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // new_month[3:0], new_day[8:4], new_year[22:9], day_of_year[31:23],
    // days_left[40:32], leap_flag[41], status[43:42], zero pad
    output logic      [gdad_pkg::M_DATA_W-1:0] m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);
    import gdad_pkg::*;

    // unit width covers the year and the day total (day of year plus count)
    localparam int W     = ((ADD_WIDTH > YEAR_W) ? ADD_WIDTH : YEAR_W) + 1;
    // bits of the count field actually used
    localparam int CNT_B = (ADD_WIDTH < COUNT_W) ? ADD_WIDTH : COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,     // reduce year modulo 400
        ST_CHECK,   // range check of month and day
        ST_DOY,     // accumulate month lengths, then the day
        ST_LEFT,    // days left in the year
        ST_TOTAL,   // day of year plus count
        ST_WALK,    // take off one month per cycle
        ST_FINISH   // hand result to output register
    } state_t;

    state_t state_reg, state_next;

    // working registers
    logic [MONTH_W-1:0]   m_reg, m_next;
    logic [DAY_W-1:0]     d_reg, d_next;
    logic [ADD_WIDTH-1:0] n_reg, n_next;
    logic [YEAR_W-1:0]    yrem_reg, yrem_next;
    logic [R400_W-1:0]    r400_reg, r400_next;
    logic [YEAR_W-1:0]    cy_reg, cy_next;
    logic [MONTH_W-1:0]   cm_reg, cm_next;
    logic [MONTH_W-1:0]   mi_reg, mi_next;
    logic [DOY_W-1:0]     doy_reg, doy_next;
    logic [DOY_W-1:0]     left_reg, left_next;
    logic [W-1:0]         total_reg, total_next;
    logic                 leap_in_reg, leap_in_next;
    status_t              stat_reg, stat_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]  out_data_reg, out_data_next;

    // shared unit
    logic [W-1:0] alu_a, alu_b, alu_sum;
    logic         alu_sub, alu_carry;

    logic               leap_cur;
    logic [DAY_W-1:0]   md_cur;
    logic               s_fire;
    logic               date_ok;
    logic [MONTH_W-1:0] res_month;
    logic [DAY_W-1:0]   res_day;
    logic [YEAR_W-1:0]  res_year;

    gdad_addsub #(
        .W(W)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum),
        .carry(alu_carry)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // leap flag of the year currently held in cy_reg
    assign leap_cur = is_leap(cy_reg[1:0], r400_reg);
    // length of the month under test in the check step
    assign md_cur   = month_days(m_reg, leap_cur);
    assign date_ok  = (m_reg >= MONTH_JAN) && (m_reg <= MONTH_DEC)
                      && (d_reg != '0) && (d_reg <= md_cur);

    // operand selection for the shared unit
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_MOD:
            begin
                alu_a   = W'(yrem_reg);
                alu_b   = W'(CYCLE_400);
                alu_sub = 1'b1;
            end
            ST_DOY:
            begin
                alu_a = W'(doy_reg);
                if (mi_reg != m_reg)
                    alu_b = W'(month_days(mi_reg, leap_cur));
                else
                    alu_b = W'(d_reg);
            end
            ST_LEFT:
            begin
                alu_a   = leap_cur ? W'(DAYS_LEAP) : W'(DAYS_NORM);
                alu_b   = W'(doy_reg);
                alu_sub = 1'b1;
            end
            ST_TOTAL:
            begin
                alu_a = W'(doy_reg);
                alu_b = W'(n_reg);
            end
            ST_WALK:
            begin
                alu_a   = total_reg;
                alu_b   = W'(month_days(cm_reg, leap_cur));
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // result fields are zero unless status is ok
    assign res_month = (stat_reg == STAT_OK) ? cm_reg : '0;
    assign res_day   = (stat_reg == STAT_OK) ? total_reg[DAY_W-1:0] : '0;
    assign res_year  = (stat_reg == STAT_OK) ? cy_reg : '0;

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        n_next         = n_reg;
        yrem_next      = yrem_reg;
        r400_next      = r400_reg;
        cy_next        = cy_reg;
        cm_next        = cm_reg;
        mi_next        = mi_reg;
        doy_next       = doy_reg;
        left_next      = left_reg;
        total_next     = total_reg;
        leap_in_next   = leap_in_reg;
        stat_next      = stat_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        // receiver takes the pending result
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    m_next     = s_tdata[3:0];
                    d_next     = s_tdata[8:4];
                    yrem_next  = s_tdata[22:9];
                    cy_next    = s_tdata[22:9];
                    n_next     = ADD_WIDTH'(s_tdata[23 +: CNT_B]);
                    cm_next    = MONTH_JAN;
                    mi_next    = MONTH_JAN;
                    doy_next   = '0;
                    left_next  = '0;
                    total_next = '0;
                    stat_next  = STAT_OK;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (alu_carry)
                    yrem_next = alu_sum[YEAR_W-1:0];
                else
                begin
                    r400_next  = yrem_reg[R400_W-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                leap_in_next = leap_cur;
                if (date_ok)
                    state_next = ST_DOY;
                else
                begin
                    stat_next  = STAT_INVALID;
                    state_next = ST_FINISH;
                end
            end
            ST_DOY:
            begin
                doy_next = alu_sum[DOY_W-1:0];
                if (mi_reg != m_reg)
                    mi_next = mi_reg + 4'd1;
                else
                    state_next = ST_LEFT;
            end
            ST_LEFT:
            begin
                left_next  = alu_sum[DOY_W-1:0];
                state_next = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                total_next = alu_sum;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (cy_reg > MAX_YEAR)
                begin
                    stat_next  = STAT_OVERFLOW;
                    state_next = ST_FINISH;
                end
                else if (alu_carry && (alu_sum != '0))
                begin
                    // more than a whole month left: step to the next month
                    total_next = alu_sum;
                    if (cm_reg == MONTH_DEC)
                    begin
                        cm_next   = MONTH_JAN;
                        cy_next   = cy_reg + 14'd1;
                        r400_next = (r400_reg == CYCLE_LAST) ? '0 : r400_reg + 9'd1;
                    end
                    else
                        cm_next = cm_reg + 4'd1;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0000, stat_reg, leap_in_reg, left_reg, doy_reg,
                                      res_year, res_day, res_month};
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        d_reg        <= d_next;
        n_reg        <= n_next;
        yrem_reg     <= yrem_next;
        r400_reg     <= r400_next;
        cy_reg       <= cy_next;
        cm_reg       <= cm_next;
        mi_reg       <= mi_next;
        doy_reg      <= doy_next;
        left_reg     <= left_next;
        total_reg    <= total_next;
        leap_in_reg  <= leap_in_next;
        stat_reg     <= stat_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: tb/tb_gregorian_date_add_days_top.sv
// self-checking testbench for the gregorian date adder: directed and random
// dates, with and without random idling on both streams; uses gdad_pkg and the rtl
`timescale 1ns / 1ps

module tb_gregorian_date_add_days_top;

    import gdad_pkg::*;

    localparam int ADD_W          = 16;
    localparam int YEAR_LIMIT     = 9999;
    localparam int WATCHDOG_LIMIT = 20000;  // idle cycles
    localparam int REPORT_CAP     = 200;

    // one input transfer, split into its fields
    typedef struct {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
    } date_req_t;

    // one output transfer, split into its fields
    typedef struct {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
        logic [DOY_W-1:0]   doy;
        logic [DOY_W-1:0]   left;
        logic               leap;
        status_t            status;
    } date_res_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    date_req_t   pending_dates [$];   // waiting to be driven
    date_res_t   expected_dates [$];  // predicted results, oldest first
    int unsigned queued_items   = 0;
    int unsigned accepted_items = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned idle_cycles    = 0;
    int unsigned src_pause      = 0;
    int unsigned sink_pause     = 0;
    bit          in_taken       = 1'b0;  // input transfer at the last rising edge
    bit          src_calm       = 1'b0;  // no gaps from the sender
    bit          snk_calm       = 1'b0;  // no stalls from the receiver

    always #4 clk = ~clk;

    gregorian_date_add_days_top #(
        .ADD_WIDTH (ADD_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // ---------------------------------------------------------------
    // calendar predictor
    // ---------------------------------------------------------------

    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // only called with a month of 1..12
    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        case (m)
            2:          return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // walk forward month by month from january of the start year
    function automatic date_res_t add_days_to_date(date_req_t r);
        date_res_t   res;
        int unsigned m, d, y, n, doy, total, cm, cy;
        m   = r.month;
        d   = r.day;
        y   = r.year;
        n   = r.count % (1 << ADD_W);
        doy = 0;
        res.month  = '0;
        res.day    = '0;
        res.year   = '0;
        res.doy    = '0;
        res.left   = '0;
        res.leap   = is_leap_year(y);
        res.status = STAT_INVALID;
        if (m < 1 || m > 12 || d < 1 || d > month_length(m, y))
            return res;
        for (int unsigned i = 1; i < m; i++)
            doy += month_length(i, y);
        doy     += d;
        res.doy  = doy;
        res.left = (res.leap ? 366 : 365) - doy;
        total = doy + n;
        cm    = 1;
        cy    = y;
        // a month comes off only while the count exceeds it, so month ends survive
        while (cy <= YEAR_LIMIT && total > month_length(cm, cy))
        begin
            total -= month_length(cm, cy);
            cm++;
            if (cm > 12)
            begin
                cm = 1;
                cy++;
            end
        end
        if (cy > YEAR_LIMIT)
            res.status = STAT_OVERFLOW;
        else
        begin
            res.status = STAT_OK;
            res.month  = cm;
            res.day    = total;
            res.year   = cy;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic date_req_t make_req(int unsigned m, int unsigned d,
                                           int unsigned y, int unsigned n);
        date_req_t r;
        r.month = m;
        r.day   = d;
        r.year  = y;
        r.count = n;
        return r;
    endfunction

    // mostly well-formed dates, some raw noise; counts mostly short
    function automatic date_req_t random_date_req();
        date_req_t   r;
        int unsigned pick, y;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            r.month = $urandom_range(15);
            r.day   = $urandom_range(31);
            r.year  = $urandom_range(16383);
            r.count = $urandom_range(65535);
            return r;
        end
        pick = $urandom_range(99);
        if (pick < 65)
            y = $urandom_range(9999, 1);
        else if (pick < 78)
            y = $urandom_range(9999, 9600);     // close to the year limit
        else if (pick < 88)
            y = 100 * $urandom_range(99);       // century years, year zero among them
        else
            y = $urandom_range(16383, 10000);   // already beyond the limit
        r.year  = y;
        r.month = $urandom_range(12, 1);
        if ($urandom_range(3) == 0)
            r.day = month_length(r.month, y);
        else
            r.day = $urandom_range(month_length(r.month, y), 1);
        pick = $urandom_range(99);
        if (pick < 55)
            r.count = $urandom_range(400);
        else if (pick < 85)
            r.count = $urandom_range(4000);
        else if (pick < 95)
            r.count = $urandom_range(65535);
        else
            r.count = '1;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned random_pause_len();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(4, 1);
        else
            return $urandom_range(90, 12);
    endfunction

    task automatic queue_request(date_req_t r);
        pending_dates.push_back(r);
        queued_items++;
    endtask

    // hold until every queued request has gone in and its result has come back
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (accepted_items != queued_items || expected_dates.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < REPORT_CAP)
            $display("[%0t] result %0d %s: got %0d, expected %0d",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // input driver: changes on the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (src_pause > 0)
            begin
                src_pause--;
                s_tvalid <= 1'b0;
            end
            else if (pending_dates.size() > 0)
            begin
                date_req_t r;
                r = pending_dates.pop_front();
                // start_month, start_day, start_year, add_count from bit 0 up
                s_tdata   <= {1'b0, r.count, r.year, r.day, r.month};
                s_tvalid  <= 1'b1;
                src_pause  = src_calm ? 0 : random_pause_len();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // output ready: random stalls unless the receiver is calm
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (snk_calm)
                m_tready <= 1'b1;
            else if (sink_pause > 0)
            begin
                sink_pause--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready   <= 1'b1;
                sink_pause  = random_pause_len();
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: sample both streams on the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        date_res_t want;
        bit        out_taken;
        in_taken  = rst_n && s_tvalid && s_tready;
        out_taken = rst_n && m_tvalid && m_tready;

        // predict at the moment the input transfer happens
        if (in_taken)
        begin
            expected_dates.push_back(add_days_to_date(make_req(s_tdata[3:0], s_tdata[8:4],
                                                               s_tdata[22:9], s_tdata[38:23])));
            accepted_items++;
        end

        // result fields: new_month, new_day, new_year, day_of_year, days_left,
        // leap_flag, status from bit 0 up
        if (out_taken)
        begin
            results_seen++;
            if (expected_dates.size() == 0)
                report_mismatch("arrived with nothing pending", m_tdata[43:42], 0);
            else
            begin
                want = expected_dates.pop_front();
                if (m_tdata[3:0] !== want.month)
                    report_mismatch("new_month", m_tdata[3:0], want.month);
                if (m_tdata[8:4] !== want.day)
                    report_mismatch("new_day", m_tdata[8:4], want.day);
                if (m_tdata[22:9] !== want.year)
                    report_mismatch("new_year", m_tdata[22:9], want.year);
                if (m_tdata[31:23] !== want.doy)
                    report_mismatch("day_of_year", m_tdata[31:23], want.doy);
                if (m_tdata[40:32] !== want.left)
                    report_mismatch("days_left", m_tdata[40:32], want.left);
                if (m_tdata[41] !== want.leap)
                    report_mismatch("leap_flag", m_tdata[41], want.leap);
                if (m_tdata[43:42] !== want.status)
                    report_mismatch("status", m_tdata[43:42], want.status);
            end
        end

        // watchdog: too long without any transfer on either side
        if (in_taken || out_taken)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence of the run
    // ---------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, month ends, leap rules, invalid dates, overflow
        queue_request(make_req(1, 1, 1, 0));
        queue_request(make_req(12, 31, 9999, 0));        // last representable day
        queue_request(make_req(12, 31, 9999, 1));        // steps past the year limit
        queue_request(make_req(2, 29, 2000, 0));         // leap by the 400 rule
        queue_request(make_req(2, 29, 1900, 0));         // century, not leap: invalid
        queue_request(make_req(2, 28, 2100, 1));         // lands on march 1st
        queue_request(make_req(2, 29, 2024, 365));
        queue_request(make_req(2, 28, 2023, 1));
        queue_request(make_req(1, 31, 2023, 28));        // ends on february 28th
        queue_request(make_req(1, 31, 2024, 29));        // ends on february 29th
        queue_request(make_req(12, 31, 2023, 1));        // year rollover
        queue_request(make_req(1, 1, 2024, 365));        // ends on december 31st
        queue_request(make_req(0, 15, 2020, 10));        // month zero
        queue_request(make_req(13, 1, 2020, 10));        // month past december
        queue_request(make_req(4, 0, 2020, 10));         // day zero
        queue_request(make_req(4, 31, 2020, 10));        // day past month end
        queue_request(make_req(15, 31, 16383, 65535));   // every input bit set
        queue_request(make_req(2, 29, 0, 0));            // year zero counts as leap
        queue_request(make_req(1, 1, 10000, 0));         // input year beyond the limit
        queue_request(make_req(12, 31, 16383, 65535));
        queue_request(make_req(1, 1, 1, 65535));         // long walk from the start of year one
        queue_request(make_req(1, 1, 9820, 65535));      // long walk near the limit
        queue_request(make_req(3, 1, 2100, 0));
        wait_until_drained();

        // random with idling on both sides
        for (int i = 0; i < 90; i++)
            queue_request(random_date_req());
        // sender holds off until every result is back
        wait_until_drained();

        // random with no idling at all
        src_calm = 1'b1;
        snk_calm = 1'b1;
        for (int i = 0; i < 70; i++)
            queue_request(random_date_req());
        wait_until_drained();

        // random with idling again
        src_calm = 1'b0;
        snk_calm = 1'b0;
        for (int i = 0; i < 88; i++)
            queue_request(random_date_req());
        wait_until_drained();

        // watch for stray results after the last one
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/gdad_pkg.sv
rtl/gdad_addsub.sv
rtl/gregorian_date_add_days_top.sv
tb/tb_gregorian_date_add_days_top.sv
